// ----- rtl/core/mras_pkg.sv -----
// Shared widths, types and stage counts for the rate split unit.
package mras_pkg;

    localparam int LEN_W       = 24;
    localparam int RATE_W      = 24;
    localparam int COMB_W      = 25;
    localparam int SQ_W        = 2 * RATE_W;
    localparam int SUM_W       = 2 * COMB_W;
    localparam int DIST_W      = 24;
    localparam int FIELD_AXES  = 3;
    localparam int SQRT_STAGES = COMB_W;
    localparam int DIV_STAGES  = DIST_W;
    localparam int LANE_LAT    = DIV_STAGES + 1;
    localparam int PRE_LAT     = 3;
    localparam int PIPE_LAT    = PRE_LAT + SQRT_STAGES + LANE_LAT;

    typedef logic [LEN_W-1:0]  len_t;
    typedef logic [RATE_W-1:0] rate_t;
    typedef logic [COMB_W-1:0] comb_t;
    typedef logic [SQ_W-1:0]   sq_t;
    typedef logic [SUM_W-1:0]  sum_t;
    typedef logic [DIST_W-1:0] dist_t;

    typedef struct packed {
        len_t                        len;
        logic [FIELD_AXES-1:0][RATE_W-1:0] rate;
    } side_t;

endpackage

// ----- rtl/core/multi_axis_rate_split_unit.sv -----
// Top level: combined rate and per-axis split of a move's path length.
// Fully pipelined: one item per cycle unless a stalled result holds the flow; from
// accept to result lie 3 input/square/sum stages, 25 root stages of one bit each,
// and per axis lane one multiply stage plus 24 divide stages. Three axis lanes run in
// parallel behind the shared root; a stalled result freezes the whole pipeline.
// With every rate zero, all outputs are zero and zero_rate is set.
module multi_axis_rate_split_unit
#(
    parameter int AXES = 3
)
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             in_valid,
    output logic             in_stall,
    input  mras_pkg::len_t   move_length,
    input  mras_pkg::rate_t  rate_x,
    input  mras_pkg::rate_t  rate_y,
    input  mras_pkg::rate_t  rate_z,
    output logic             out_valid,
    input  logic             out_stall,
    output mras_pkg::comb_t  combined_rate,
    output mras_pkg::dist_t  dist_x,
    output mras_pkg::dist_t  dist_y,
    output mras_pkg::dist_t  dist_z,
    output logic             zero_rate
);
    import mras_pkg::*;

    logic             en;
    logic [PIPE_LAT-1:0] vld_reg;
    logic [PIPE_LAT-1:0] vld_next;

    rate_t            rate_in [0:FIELD_AXES-1];
    len_t             len_s1_reg;
    rate_t            rate_s1_reg [0:FIELD_AXES-1];
    len_t             len_s2_reg;
    rate_t            rate_s2_reg [0:FIELD_AXES-1];
    sq_t              sq_reg [0:FIELD_AXES-1];
    side_t            side_s3_reg;
    sum_t             sum_reg;
    comb_t            root;
    side_t            side_rt;
    comb_t            comb_dly_reg [0:LANE_LAT-1];
    dist_t            lane_dist [0:FIELD_AXES-1];
    logic             zero;

    assign en       = !(vld_reg[PIPE_LAT-1] && out_stall);
    assign in_stall = !en;
    assign vld_next = {vld_reg[PIPE_LAT-2:0], in_valid};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else if (en)
        begin
            vld_reg <= vld_next;
        end
    end

    assign rate_in[0] = rate_x;
    assign rate_in[1] = rate_y;
    assign rate_in[2] = rate_z;

    genvar i;
    generate
        for (i = 0; i < FIELD_AXES; i++)
        begin : g_axis
            mras_lane u_lane
            (
                .clk  (clk),
                .en   (en),
                .len  (side_rt.len),
                .rate (side_rt.rate[i]),
                .comb (root),
                .quot (lane_dist[i])
            );
        end
    endgenerate

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            len_s1_reg      <= move_length;
            len_s2_reg      <= len_s1_reg;
            side_s3_reg.len <= len_s2_reg;
            sum_reg         <= {2'b00, sq_reg[0]} + {2'b00, sq_reg[1]} + {2'b00, sq_reg[2]};
            for (int a = 0; a < FIELD_AXES; a++)
            begin
                rate_s1_reg[a]      <= (a < AXES) ? rate_in[a] : '0;
                sq_reg[a]           <= rate_s1_reg[a] * rate_s1_reg[a];
                rate_s2_reg[a]      <= rate_s1_reg[a];
                side_s3_reg.rate[a] <= rate_s2_reg[a];
            end
        end
    end

    mras_sqrt u_sqrt
    (
        .clk      (clk),
        .en       (en),
        .sum      (sum_reg),
        .side_in  (side_s3_reg),
        .root     (root),
        .side_out (side_rt)
    );

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            comb_dly_reg[0] <= root;
            for (int k = 1; k < LANE_LAT; k++)
            begin
                comb_dly_reg[k] <= comb_dly_reg[k-1];
            end
        end
    end

    assign zero          = (comb_dly_reg[LANE_LAT-1] == '0);
    assign out_valid     = vld_reg[PIPE_LAT-1];
    assign combined_rate = comb_dly_reg[LANE_LAT-1];
    assign zero_rate     = zero;
    assign dist_x        = zero ? '0 : lane_dist[0];
    assign dist_y        = zero ? '0 : lane_dist[1];
    assign dist_z        = zero ? '0 : lane_dist[2];

endmodule

// ----- rtl/core/mras_sqrt.sv -----
// Pipelined integer square root, one root bit per stage, with carried side data.
module mras_sqrt
(
    input  logic            clk,
    input  logic            en,
    input  mras_pkg::sum_t  sum,
    input  mras_pkg::side_t side_in,
    output mras_pkg::comb_t root,
    output mras_pkg::side_t side_out
);
    import mras_pkg::*;

    localparam int REM_W = COMB_W + 3;

    logic [REM_W-1:0]  rem_reg  [0:SQRT_STAGES-1];
    comb_t             root_reg [0:SQRT_STAGES-1];
    sum_t              vlo_reg  [0:SQRT_STAGES-1];
    side_t             side_reg [0:SQRT_STAGES-1];

    genvar k;
    generate
        for (k = 0; k < SQRT_STAGES; k++)
        begin : g_stage
            logic [REM_W-1:0] rem_in;
            comb_t            root_in;
            sum_t             vlo_in;
            side_t            side_st;
            logic [REM_W-1:0] r2;
            logic [REM_W-1:0] trial;

            if (k == 0)
            begin : g_first
                assign rem_in  = '0;
                assign root_in = '0;
                assign vlo_in  = sum;
                assign side_st = side_in;
            end
            else
            begin : g_next
                assign rem_in  = rem_reg[k-1];
                assign root_in = root_reg[k-1];
                assign vlo_in  = vlo_reg[k-1];
                assign side_st = side_reg[k-1];
            end

            assign r2    = {rem_in[REM_W-3:0], vlo_in[SUM_W-1:SUM_W-2]};
            assign trial = {1'b0, root_in, 2'b01};

            always_ff @(posedge clk)
            begin
                if (en)
                begin
                    if (r2 >= trial)
                    begin
                        rem_reg[k]  <= r2 - trial;
                        root_reg[k] <= {root_in[COMB_W-2:0], 1'b1};
                    end
                    else
                    begin
                        rem_reg[k]  <= r2;
                        root_reg[k] <= {root_in[COMB_W-2:0], 1'b0};
                    end
                    vlo_reg[k]  <= {vlo_in[SUM_W-3:0], 2'b00};
                    side_reg[k] <= side_st;
                end
            end
        end
    endgenerate

    assign root     = root_reg[SQRT_STAGES-1];
    assign side_out = side_reg[SQRT_STAGES-1];

endmodule

// ----- rtl/core/mras_lane.sv -----
// One axis lane: length times rate, then a pipelined rounded divide by the combined rate.
module mras_lane
(
    input  logic            clk,
    input  logic            en,
    input  mras_pkg::len_t  len,
    input  mras_pkg::rate_t rate,
    input  mras_pkg::comb_t comb,
    output mras_pkg::dist_t quot
);
    import mras_pkg::*;

    localparam int NUM_W = LEN_W + RATE_W + 1;

    logic [LEN_W+RATE_W-1:0] prod_reg;
    comb_t                   half_reg;
    comb_t                   d0_reg;

    comb_t                   rem_reg [0:DIV_STAGES-1];
    logic [DIST_W-1:0]       lo_reg  [0:DIV_STAGES-1];
    dist_t                   q_reg   [0:DIV_STAGES-1];
    comb_t                   d_reg   [0:DIV_STAGES-1];

    logic [NUM_W-1:0]        num;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            prod_reg <= len * rate;
            half_reg <= {1'b0, comb[COMB_W-1:1]};
            d0_reg   <= comb;
        end
    end

    assign num = {1'b0, prod_reg} + {{(NUM_W-COMB_W){1'b0}}, half_reg};

    genvar k;
    generate
        for (k = 0; k < DIV_STAGES; k++)
        begin : g_stage
            comb_t             rem_in;
            logic [DIST_W-1:0] lo_in;
            dist_t             q_in;
            comb_t             d_in;
            logic [COMB_W:0]   t;

            if (k == 0)
            begin : g_first
                assign rem_in = num[NUM_W-1:DIST_W];
                assign lo_in  = num[DIST_W-1:0];
                assign q_in   = '0;
                assign d_in   = d0_reg;
            end
            else
            begin : g_next
                assign rem_in = rem_reg[k-1];
                assign lo_in  = lo_reg[k-1];
                assign q_in   = q_reg[k-1];
                assign d_in   = d_reg[k-1];
            end

            assign t = {rem_in, lo_in[DIST_W-1]};

            always_ff @(posedge clk)
            begin
                if (en)
                begin
                    if (t >= {1'b0, d_in})
                    begin
                        rem_reg[k] <= COMB_W'(t - {1'b0, d_in});
                        q_reg[k]   <= {q_in[DIST_W-2:0], 1'b1};
                    end
                    else
                    begin
                        rem_reg[k] <= t[COMB_W-1:0];
                        q_reg[k]   <= {q_in[DIST_W-2:0], 1'b0};
                    end
                    lo_reg[k] <= {lo_in[DIST_W-2:0], 1'b0};
                    d_reg[k]  <= d_in;
                end
            end
        end
    endgenerate

    assign quot = q_reg[DIV_STAGES-1];

endmodule

// ----- rtl/core/mras_checker.sv -----
// Port-level checks for the rate split unit, bound to the top level.
module mras_checker
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             in_stall,
    input  logic             out_valid,
    input  logic             out_stall,
    input  mras_pkg::comb_t  combined_rate,
    input  mras_pkg::dist_t  dist_x,
    input  mras_pkg::dist_t  dist_y,
    input  mras_pkg::dist_t  dist_z,
    input  logic             zero_rate
);

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(combined_rate)
            && $stable(dist_x) && $stable(dist_y) && $stable(dist_z))
        else $error("result changed while stalled");

    a_no_stall_idle: assert property (@(posedge clk) disable iff (!rst_n)
        !(out_valid && out_stall) |-> !in_stall)
        else $error("input stalled while output free");

    a_zero_outputs: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && zero_rate |-> combined_rate == '0 && dist_x == '0
            && dist_y == '0 && dist_z == '0)
        else $error("zero rate with nonzero outputs");

    a_zero_flag: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !zero_rate |-> combined_rate != '0)
        else $error("zero combined rate without flag");

endmodule

bind multi_axis_rate_split_unit mras_checker u_mras_checker
(
    .clk           (clk),
    .rst_n         (rst_n),
    .in_stall      (in_stall),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .combined_rate (combined_rate),
    .dist_x        (dist_x),
    .dist_y        (dist_y),
    .dist_z        (dist_z),
    .zero_rate     (zero_rate)
);
